@@ rtl/pwr_pkg.sv @@
// Package for the particle weight resampler.
// Holds the fixed payload widths that are shared by the interfaces and the top level.
package pwr_pkg;

    // Width of the weight field on the input channel.
    localparam int unsigned WEIGHT_IN_W = 16;

    // Width of the source index field on the output channel.
    localparam int unsigned INDEX_OUT_W = 6;

endpackage

@@ rtl/pwr_if.sv @@
// Valid/ready channel interfaces for the particle weight resampler.
// Depends on pwr_pkg for the payload widths.
interface pwr_weight_if;
    logic                               valid;
    logic                               ready;
    logic [pwr_pkg::WEIGHT_IN_W-1:0]    weight;
    logic                               last_weight;

    modport source (output valid, output weight, output last_weight, input ready);
    modport sink   (input valid, input weight, input last_weight, output ready);
endinterface

interface pwr_index_if;
    logic                               valid;
    logic                               ready;
    logic [pwr_pkg::INDEX_OUT_W-1:0]    source_index;
    logic                               last_copy;

    modport source (output valid, output source_index, output last_copy, input ready);
    modport sink   (input valid, input source_index, input last_copy, output ready);
endinterface

@@ rtl/particle_weight_resampler_unit.sv @@
// Top level of the particle weight resampler: weight store, set sequencer, output register.
// Depends on pwr_pkg, the interfaces in pwr_if and the divider pwr_serial_div.
//
// Usage: weights arrive one beat at a time on i_weight (valid/ready). Each beat is
// stored and added to the running sum; a beat with last_weight set closes the set.
// Up to MAX_PARTICLES weights are kept; later beats of an overfull set are dropped.
// After the closing beat the block emits exactly n beats on o_index, n being the
// number of stored weights: particle i is repeated round(w_i*n/sum) times (ties to
// even), output stops at n beats, and missing slots are filled with index 0.
// last_copy marks the n-th beat. i_weight.ready is low while a set is being emitted.
// Timing: weights are taken one per cycle while loading. The copy count of each
// particle then comes from the bit-serial divider, which runs one quotient bit a
// cycle; copies, padding beats and a zero-sum set go out at one beat a cycle
// while the receiver does not stall, and the sequencer waits while it does.
// Reset (synchronous, active low) clears the sum, the counters and the output
// valid; stored weights are not cleared, only entries of the current set are read.
// A stalled receiver holds the output register; the sequencer waits on it.
module particle_weight_resampler_unit #(
    parameter int unsigned MAX_PARTICLES = 64,
    parameter int unsigned WEIGHT_BITS   = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pwr_weight_if.sink    i_weight,
    pwr_index_if.source   o_index
);

    localparam int unsigned IdxW = $clog2(MAX_PARTICLES);
    localparam int unsigned CntW = $clog2(MAX_PARTICLES + 1);
    localparam int unsigned SumW = WEIGHT_BITS + IdxW;

    typedef enum logic [2:0] {
        S_LOAD,
        S_READ,
        S_MUL,
        S_DIV,
        S_EMIT,
        S_PAD
    } t_state;

    t_state                 r_state;
    logic [WEIGHT_BITS-1:0] r_mem [MAX_PARTICLES];
    logic [WEIGHT_BITS-1:0] r_rdata;
    logic [SumW-1:0]        r_sum;
    logic [CntW-1:0]        r_load_cnt;
    logic [CntW-1:0]        r_n;
    logic [CntW-1:0]        r_emit;
    logic [IdxW-1:0]        r_idx;
    logic [CntW-1:0]        r_copies;
    logic                   r_out_valid;
    logic [IdxW-1:0]        r_out_idx;
    logic                   r_out_last;

    logic [WEIGHT_BITS-1:0] w_wval;
    logic                   w_accept;
    logic                   w_full;
    logic                   w_store;
    logic [CntW-1:0]        n_load_cnt;
    logic [SumW-1:0]        n_sum;
    logic                   w_out_free;
    logic                   w_out_load;
    logic                   w_emit_last;
    logic                   w_idx_last;
    logic                   w_div_done;
    logic [CntW-1:0]        w_div_copies;

    // Input side: take the low WEIGHT_BITS of the weight field.
    assign w_wval          = WEIGHT_BITS'(i_weight.weight);
    assign i_weight.ready  = (r_state == S_LOAD);
    assign w_accept        = i_weight.valid && i_weight.ready;
    assign w_full          = (r_load_cnt == CntW'(MAX_PARTICLES));
    assign w_store         = w_accept && !w_full;
    assign n_load_cnt      = w_full ? r_load_cnt : r_load_cnt + CntW'(1);
    assign n_sum           = w_full ? r_sum : r_sum + SumW'(w_wval);

    // Output side and end-of-set tests.
    assign w_out_free   = !r_out_valid || o_index.ready;
    assign w_out_load   = w_out_free &&
                          ((r_state == S_EMIT && r_copies != '0) || r_state == S_PAD);
    assign w_emit_last  = ((r_emit + CntW'(1)) == r_n);
    assign w_idx_last   = ((CntW'(r_idx) + CntW'(1)) == r_n);

    assign o_index.valid        = r_out_valid;
    assign o_index.source_index = pwr_pkg::INDEX_OUT_W'(r_out_idx);
    assign o_index.last_copy    = r_out_last;

    // Weight store: written while loading, read at the current particle.
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_mem[r_load_cnt[IdxW-1:0]] <= w_wval;
        end
        r_rdata <= r_mem[r_idx];
    end

    // Copy count for the particle whose weight was just read.
    pwr_serial_div #(
        .WEIGHT_BITS (WEIGHT_BITS),
        .IDX_BITS    (IdxW),
        .CNT_BITS    (CntW)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == S_MUL),
        .i_weight (r_rdata),
        .i_count  (r_n),
        .i_sum    (r_sum),
        .o_done   (w_div_done),
        .o_copies (w_div_copies)
    );

    // Set sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_sum       <= '0;
            r_load_cnt  <= '0;
            r_n         <= '0;
            r_emit      <= '0;
            r_idx       <= '0;
            r_copies    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A new beat loads the output register; otherwise a taken beat empties it.
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_index.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (w_accept) begin
                        r_sum      <= n_sum;
                        r_load_cnt <= n_load_cnt;
                        if (i_weight.last_weight) begin
                            r_n    <= n_load_cnt;
                            r_idx  <= '0;
                            r_emit <= '0;
                            if (n_sum == '0) begin
                                r_state <= S_PAD;
                            end else begin
                                r_state <= S_READ;
                            end
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_copies <= w_div_copies;
                        r_state  <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (r_copies == '0) begin
                        if (w_idx_last) begin
                            r_state <= S_PAD;
                        end else begin
                            r_idx   <= r_idx + IdxW'(1);
                            r_state <= S_READ;
                        end
                    end else if (w_out_free) begin
                        r_out_idx   <= r_idx;
                        r_out_last  <= w_emit_last;
                        r_emit      <= w_emit_last ? '0 : r_emit + CntW'(1);
                        r_copies    <= r_copies - CntW'(1);
                        if (w_emit_last) begin
                            r_state    <= S_LOAD;
                            r_sum      <= '0;
                            r_load_cnt <= '0;
                        end
                    end
                end
                S_PAD: begin
                    if (w_out_free) begin
                        r_out_idx   <= '0;
                        r_out_last  <= w_emit_last;
                        r_emit      <= w_emit_last ? '0 : r_emit + CntW'(1);
                        if (w_emit_last) begin
                            r_state    <= S_LOAD;
                            r_sum      <= '0;
                            r_load_cnt <= '0;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // The emitted count never runs past the set size while a set is out.
    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT || r_state == S_PAD) |-> (r_emit < r_n))
        else $error("emitted count passed the set size");

    // The load count never passes the store depth.
    a_load_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_cnt <= CntW'(MAX_PARTICLES))
        else $error("load count passed the store depth");

    // The divider reports only while the sequencer waits for it.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider result arrived outside the wait state");

    // A beat marked last returns the sequencer to loading with an empty set.
    a_last_ends_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT || r_state == S_PAD) && w_out_free && w_emit_last &&
         !(r_state == S_EMIT && r_copies == '0))
        |=> (r_state == S_LOAD && r_load_cnt == '0 && r_out_last))
        else $error("set did not close on its last beat");
`endif

endmodule

@@ rtl/pwr_serial_div.sv @@
// Bit-serial restoring divider with round-half-to-even for the copy count.
// Computes round(weight * n / sum); stand-alone, uses no package items.
module pwr_serial_div #(
    parameter int unsigned WEIGHT_BITS = 16,
    parameter int unsigned IDX_BITS    = 6,
    parameter int unsigned CNT_BITS    = 7
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [WEIGHT_BITS-1:0]             i_weight,
    input  logic [CNT_BITS-1:0]                i_count,
    input  logic [WEIGHT_BITS+IDX_BITS-1:0]    i_sum,
    output logic                               o_done,
    output logic [CNT_BITS-1:0]                o_copies
);

    localparam int unsigned SumW  = WEIGHT_BITS + IDX_BITS;
    localparam int unsigned ProdW = WEIGHT_BITS + CNT_BITS;
    localparam int unsigned StepW = $clog2(ProdW + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_ROUND
    } t_div_state;

    t_div_state         r_state;
    logic [StepW-1:0]   r_step;
    logic [ProdW-1:0]   r_quo;
    logic [SumW-1:0]    r_rem;

    logic [SumW:0]      w_trial;
    logic               w_fits;
    logic [SumW:0]      w_twice;
    logic               w_round_up;

    // One quotient bit per cycle: shift the next numerator bit into the remainder.
    assign w_trial = {r_rem, r_quo[ProdW-1]};
    assign w_fits  = (w_trial >= {1'b0, i_sum});

    // Round half to even on the final remainder.
    assign w_twice    = {r_rem, 1'b0};
    assign w_round_up = (w_twice > {1'b0, i_sum}) ||
                        ((w_twice == {1'b0, i_sum}) && r_quo[0]);

    // Sequencer, datapath registers and the registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_quo   <= ProdW'(i_weight) * ProdW'(i_count);
                        r_rem   <= '0;
                        r_step  <= StepW'(ProdW);
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (w_fits) begin
                        r_rem <= SumW'(w_trial - {1'b0, i_sum});
                    end else begin
                        r_rem <= w_trial[SumW-1:0];
                    end
                    r_quo  <= {r_quo[ProdW-2:0], w_fits};
                    r_step <= r_step - StepW'(1);
                    if (r_step == StepW'(1)) begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    o_copies <= r_quo[CNT_BITS-1:0] + CNT_BITS'(w_round_up);
                    o_done   <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
